// ===== design/u8wvc_pkg.sv =====
// u8wvc_pkg: types, character codes and classification functions for the
// utf8 word and vowel counter; no dependencies
package u8wvc_pkg;

    localparam int NUM_COUNTS = 7;
    localparam int COUNT_W    = 16;

    typedef logic [COUNT_W-1:0] count_t;
    typedef count_t [NUM_COUNTS-1:0] counts_t;

    // index of the word count in counts_t
    localparam logic [2:0] IDX_WORD = 3'd0;

    // vowel classes, A E I O U Y, and a code for none
    typedef logic [2:0] vclass_t;
    localparam vclass_t CLS_A    = 3'd0;
    localparam vclass_t CLS_E    = 3'd1;
    localparam vclass_t CLS_I    = 3'd2;
    localparam vclass_t CLS_O    = 3'd3;
    localparam vclass_t CLS_U    = 3'd4;
    localparam vclass_t CLS_Y    = 3'd5;
    localparam vclass_t CLS_NONE = 3'd6;

    // lead byte thresholds
    localparam logic [7:0] LEAD_TWO   = 8'd192;
    localparam logic [7:0] LEAD_THREE = 8'd224;
    localparam logic [7:0] LEAD_FOUR  = 8'd240;

    // apostrophes never open a word
    localparam logic [23:0] APOS_ASCII = 24'h000027;
    localparam logic [23:0] APOS_LEFT  = 24'hE28098;
    localparam logic [23:0] APOS_RIGHT = 24'hE28099;

    function automatic logic is_sep(input logic [23:0] v);
        logic r;
        begin
            unique case (v)
                24'h000000, 24'h000020, 24'h000009, 24'h00000A, 24'h00000D,
                24'h000021, 24'h000022, 24'h000028, 24'h000029, 24'h00002E,
                24'h00002C, 24'h00003A, 24'h00003B, 24'h00003F, 24'h00005B,
                24'h00005D, 24'h00002D,
                24'hE2809C, 24'hE2809D, 24'hE28093, 24'hE280A6,
                24'h00C2AB, 24'h00C2BB, 24'hE28094: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    function automatic vclass_t vowel_of(input logic [23:0] v);
        vclass_t r;
        begin
            unique case (v)
                24'h000041, 24'h000061, 24'h00C3A0, 24'h00C3A1, 24'h00C3A2,
                24'h00C3A3, 24'h00C380, 24'h00C381, 24'h00C382,
                24'h00C383: r = CLS_A;
                24'h000045, 24'h000065, 24'h00C3A8, 24'h00C3A9, 24'h00C3AA,
                24'h00C388, 24'h00C389, 24'h00C38A: r = CLS_E;
                24'h000049, 24'h000069, 24'h00C3AC, 24'h00C3AD, 24'h00C38C,
                24'h00C38D: r = CLS_I;
                24'h00004F, 24'h00006F, 24'h00C3B2, 24'h00C3B3, 24'h00C3B4,
                24'h00C3B5, 24'h00C392, 24'h00C393, 24'h00C394,
                24'h00C395: r = CLS_O;
                24'h000055, 24'h000075, 24'h00C3B9, 24'h00C3BA, 24'h00C399,
                24'h00C39A: r = CLS_U;
                24'h000059, 24'h000079: r = CLS_Y;
                default: r = CLS_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic count_t sat_inc(input count_t c);
        begin
            return (c == '1) ? c : c + count_t'(1);
        end
    endfunction

endpackage

// ===== design/utf8_word_vowel_counter_top.sv =====
// utf8_word_vowel_counter_top: byte-wide utf8 word and vowel counter
// depends on u8wvc_pkg
//
// usage: text bytes enter on the text channel (text_valid / text_stall), one
// request per byte, last_in_chunk set on the final byte of a chunk. every
// byte is classified and folded into the running counts in the cycle it is
// accepted, so one byte per cycle is sustained while text_stall is low. non-final bytes give no
// result. the final byte's request produces one result on the count channel
// (count_valid / count_stall) with seven saturating 16-bit counts; all
// character and count state is cleared at the edge that accepts that byte,
// so the next chunk may follow at once.
// the result sits in an output register backed by one skid register. while
// the receiver stalls, further bytes are still taken; a second finished
// result lands in the skid register, and only then is text_stall raised,
// until the receiver takes a result.
// reset (rst_n low, asynchronous) clears the counts, the word and vowel state,
// the partial character, and drops any held result.
module utf8_word_vowel_counter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_in_chunk,
    output logic        count_valid,
    input  logic        count_stall,
    output logic [15:0] word_count,
    output logic [15:0] words_with_a,
    output logic [15:0] words_with_e,
    output logic [15:0] words_with_i,
    output logic [15:0] words_with_o,
    output logic [15:0] words_with_u,
    output logic [15:0] words_with_y
);

    logic                in_word_reg, in_word_next;
    logic [5:0]          flags_reg, flags_next;
    logic [1:0]          expect_reg, expect_next;
    logic [23:0]         acc_reg, acc_next;
    logic                four_reg, four_next;
    u8wvc_pkg::counts_t  counts_reg, counts_next;

    logic                out_valid_reg;
    u8wvc_pkg::counts_t  out_reg;
    logic                skid_valid_reg;
    u8wvc_pkg::counts_t  skid_reg;

    logic                in_acc;
    logic                res_valid;
    logic                out_take;
    logic                char_done;
    logic                sep;
    logic                apos;
    u8wvc_pkg::vclass_t  cls;
    u8wvc_pkg::counts_t  upd_counts;
    logic [5:0]          upd_flags;
    logic                upd_in_word;

    assign text_stall = skid_valid_reg;
    assign in_acc     = text_valid && !text_stall;
    assign res_valid  = in_acc && last_in_chunk;
    assign out_take   = out_valid_reg && !count_stall;

    // character assembly
    always_comb
    begin
        if (expect_reg == 2'd0)
        begin
            acc_next  = {16'h0000, text_byte};
            four_next = (text_byte >= u8wvc_pkg::LEAD_FOUR);
            if (text_byte < u8wvc_pkg::LEAD_TWO)
                expect_next = 2'd0;
            else if (text_byte < u8wvc_pkg::LEAD_THREE)
                expect_next = 2'd1;
            else if (text_byte < u8wvc_pkg::LEAD_FOUR)
                expect_next = 2'd2;
            else
                expect_next = 2'd3;
        end
        else
        begin
            acc_next    = {acc_reg[15:0], text_byte};
            four_next   = four_reg;
            expect_next = expect_reg - 2'd1;
        end
    end

    // four-byte characters match no listed code
    assign char_done = (expect_next == 2'd0);
    assign sep  = !four_next && u8wvc_pkg::is_sep(acc_next);
    assign apos = !four_next && ((acc_next == u8wvc_pkg::APOS_ASCII) ||
                                 (acc_next == u8wvc_pkg::APOS_LEFT) ||
                                 (acc_next == u8wvc_pkg::APOS_RIGHT));
    assign cls  = four_next ? u8wvc_pkg::CLS_NONE : u8wvc_pkg::vowel_of(acc_next);

    always_comb
    begin
        upd_counts  = counts_reg;
        upd_flags   = flags_reg;
        upd_in_word = in_word_reg;
        if (char_done)
        begin
            if (sep)
            begin
                upd_in_word = 1'b0;
                upd_flags   = 6'd0;
            end
            else
            begin
                if (!in_word_reg && !apos)
                begin
                    upd_counts[u8wvc_pkg::IDX_WORD] =
                        u8wvc_pkg::sat_inc(counts_reg[u8wvc_pkg::IDX_WORD]);
                    upd_in_word = 1'b1;
                end
                if (cls != u8wvc_pkg::CLS_NONE && !flags_reg[cls])
                begin
                    upd_counts[cls + 3'd1] = u8wvc_pkg::sat_inc(counts_reg[cls + 3'd1]);
                    upd_flags[cls]         = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        counts_next  = upd_counts;
        flags_next   = upd_flags;
        in_word_next = upd_in_word;
        if (last_in_chunk)
        begin
            counts_next  = '0;
            flags_next   = 6'd0;
            in_word_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            flags_reg   <= 6'd0;
            expect_reg  <= 2'd0;
            acc_reg     <= 24'd0;
            four_reg    <= 1'b0;
            counts_reg  <= '0;
        end
        else if (in_acc)
        begin
            in_word_reg <= in_word_next;
            flags_reg   <= flags_next;
            expect_reg  <= last_in_chunk ? 2'd0 : expect_next;
            acc_reg     <= last_in_chunk ? 24'd0 : acc_next;
            four_reg    <= last_in_chunk ? 1'b0 : four_next;
            counts_reg  <= counts_next;
        end
    end

    // output register with one skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_valid)
                out_reg <= upd_counts;
        end
        else if (res_valid)
            skid_reg <= upd_counts;
    end

    assign count_valid  = out_valid_reg;
    assign word_count   = out_reg[0];
    assign words_with_a = out_reg[1];
    assign words_with_e = out_reg[2];
    assign words_with_i = out_reg[3];
    assign words_with_o = out_reg[4];
    assign words_with_u = out_reg[5];
    assign words_with_y = out_reg[6];

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with output register empty");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid_reg)
        else $error("final byte did not produce a result");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (counts_reg == '0 && expect_reg == 2'd0 && !in_word_reg))
        else $error("state not cleared after final byte");

    a_flags_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg != 6'd0) |-> in_word_reg)
        else $error("vowel flag set outside a word");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && count_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule

// ===== tb/u8wvc_tb_pkg.sv =====
`timescale 1ns / 100ps
// u8wvc_tb_pkg: expected-count tracker for the utf8 word and vowel counter,
// folds each accepted byte into running chunk counts and checks results
// depends on u8wvc_pkg
package u8wvc_tb_pkg;

    import u8wvc_pkg::*;

    localparam logic [31:0] BREAK_CODES [24] = '{
        32'h00, 32'h20, 32'h09, 32'h0A, 32'h0D, 32'h21, 32'h22, 32'h28,
        32'h29, 32'h2E, 32'h2C, 32'h3A, 32'h3B, 32'h3F, 32'h5B, 32'h5D,
        32'h2D, 32'hE2809C, 32'hE2809D, 32'hE28093, 32'hE280A6, 32'hC2AB,
        32'hC2BB, 32'hE28094
    };

    localparam logic [31:0] VOWEL_CODES [42] = '{
        32'h41, 32'h61, 32'hC3A0, 32'hC3A1, 32'hC3A2, 32'hC3A3, 32'hC380,
        32'hC381, 32'hC382, 32'hC383,
        32'h45, 32'h65, 32'hC3A8, 32'hC3A9, 32'hC3AA, 32'hC388, 32'hC389,
        32'hC38A,
        32'h49, 32'h69, 32'hC3AC, 32'hC3AD, 32'hC38C, 32'hC38D,
        32'h4F, 32'h6F, 32'hC3B2, 32'hC3B3, 32'hC3B4, 32'hC3B5, 32'hC392,
        32'hC393, 32'hC394, 32'hC395,
        32'h55, 32'h75, 32'hC3B9, 32'hC3BA, 32'hC399, 32'hC39A,
        32'h59, 32'h79
    };

    localparam vclass_t VOWEL_CLASS [42] = '{
        CLS_A, CLS_A, CLS_A, CLS_A, CLS_A, CLS_A, CLS_A, CLS_A, CLS_A, CLS_A,
        CLS_E, CLS_E, CLS_E, CLS_E, CLS_E, CLS_E, CLS_E, CLS_E,
        CLS_I, CLS_I, CLS_I, CLS_I, CLS_I, CLS_I,
        CLS_O, CLS_O, CLS_O, CLS_O, CLS_O, CLS_O, CLS_O, CLS_O, CLS_O, CLS_O,
        CLS_U, CLS_U, CLS_U, CLS_U, CLS_U, CLS_U,
        CLS_Y, CLS_Y
    };

    class chunk_tally;
        bit          in_word;
        logic [5:0]  vowels_seen;
        logic [1:0]  bytes_owed;
        logic [31:0] char_bits;
        counts_t     counts;
        counts_t     expected_counts [$];
        int          mismatches;
        int          results_checked;
        string       count_names [NUM_COUNTS];

        function new();
            count_names = '{"word_count", "words_with_a", "words_with_e",
                            "words_with_i", "words_with_o", "words_with_u",
                            "words_with_y"};
            clear_chunk();
        endfunction

        function void clear_chunk();
            in_word     = 1'b0;
            vowels_seen = '0;
            bytes_owed  = '0;
            char_bits   = '0;
            counts      = '0;
        endfunction

        // classify one complete character and update the chunk counts
        function void fold_char(logic [31:0] c);
            int      k;
            bit      is_break;
            vclass_t cls;
            is_break = 1'b0;
            cls      = CLS_NONE;
            for (k = 0; k < 24; k++)
                if (BREAK_CODES[k] == c)
                    is_break = 1'b1;
            if (is_break)
            begin
                in_word     = 1'b0;
                vowels_seen = '0;
                return;
            end
            if (!in_word && c != {8'h0, APOS_ASCII} && c != {8'h0, APOS_LEFT}
                && c != {8'h0, APOS_RIGHT})
            begin
                if (counts[IDX_WORD] != '1)
                    counts[IDX_WORD] = counts[IDX_WORD] + 1'b1;
                in_word = 1'b1;
            end
            for (k = 0; k < 42; k++)
                if (VOWEL_CODES[k] == c)
                    cls = VOWEL_CLASS[k];
            if (cls != CLS_NONE && !vowels_seen[cls])
            begin
                if (counts[cls + 1] != '1)
                    counts[cls + 1] = counts[cls + 1] + 1'b1;
                vowels_seen[cls] = 1'b1;
            end
        endfunction

        // note one accepted byte request
        function void take_byte(logic [7:0] b, logic last);
            if (bytes_owed == 2'd0)
            begin
                char_bits = {24'h0, b};
                if (b < LEAD_TWO)
                    bytes_owed = 2'd0;
                else if (b < LEAD_THREE)
                    bytes_owed = 2'd1;
                else if (b < LEAD_FOUR)
                    bytes_owed = 2'd2;
                else
                    bytes_owed = 2'd3;
            end
            else
            begin
                char_bits  = {char_bits[23:0], b};
                bytes_owed = bytes_owed - 2'd1;
            end
            if (bytes_owed == 2'd0)
                fold_char(char_bits);
            // a partial character at the end of the chunk is simply dropped
            if (last)
            begin
                expected_counts.push_back(counts);
                clear_chunk();
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task compare_counts(counts_t got);
            int      k;
            counts_t want;
            if (expected_counts.size() == 0)
            begin
                flag_mismatch("count result with no chunk outstanding");
                return;
            end
            want = expected_counts.pop_front();
            results_checked++;
            for (k = 0; k < NUM_COUNTS; k++)
                if (got[k] !== want[k])
                    flag_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                            results_checked, count_names[k],
                                            got[k], want[k]));
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for utf8_word_vowel_counter_top, drives text
// chunks with random gaps and receiver stalls; depends on u8wvc_pkg, u8wvc_tb_pkg
module tb_top;

    import u8wvc_pkg::*;
    import u8wvc_tb_pkg::*;

    localparam int RAND_BYTES     = 700;
    localparam int MIN_CHUNKS     = 48;
    localparam int HOLD_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        text_valid;
    logic        text_stall;
    logic [7:0]  text_byte;
    logic        last_in_chunk;
    logic        count_valid;
    logic        count_stall;
    logic [15:0] word_count;
    logic [15:0] words_with_a;
    logic [15:0] words_with_e;
    logic [15:0] words_with_i;
    logic [15:0] words_with_o;
    logic [15:0] words_with_u;
    logic [15:0] words_with_y;
    counts_t     result_counts;

    bit          src_gaps_on;
    bit          sink_stalls_on;
    bit          hold_req;
    int          bytes_sent;
    int          chunks_sent;
    int          quiet_cycles;
    logic [7:0]  chunk_q [$];
    chunk_tally  tally = new();

    utf8_word_vowel_counter_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .last_in_chunk (last_in_chunk),
        .count_valid   (count_valid),
        .count_stall   (count_stall),
        .word_count    (word_count),
        .words_with_a  (words_with_a),
        .words_with_e  (words_with_e),
        .words_with_i  (words_with_i),
        .words_with_o  (words_with_o),
        .words_with_u  (words_with_u),
        .words_with_y  (words_with_y)
    );

    assign result_counts = {words_with_y, words_with_u, words_with_o, words_with_i,
                            words_with_e, words_with_a, word_count};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // append a character code, most significant nonzero byte first
    function automatic void push_code(input logic [31:0] c);
        if (c[31:24] != 8'h0)
            chunk_q.push_back(c[31:24]);
        if (c[31:16] != 16'h0)
            chunk_q.push_back(c[23:16]);
        if (c[31:8] != 24'h0)
            chunk_q.push_back(c[15:8]);
        chunk_q.push_back(c[7:0]);
    endfunction

    function automatic void add_random_char();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            push_code(32'(($urandom_range(0, 1) != 0 ? 65 : 97) + $urandom_range(0, 25)));
        else if (pick < 45)
            push_code(BREAK_CODES[$urandom_range(0, 23)]);
        else if (pick < 65)
            push_code(VOWEL_CODES[$urandom_range(0, 41)]);
        else if (pick < 72)
        begin
            case ($urandom_range(0, 2))
                0:       push_code({8'h0, APOS_ASCII});
                1:       push_code({8'h0, APOS_LEFT});
                default: push_code({8'h0, APOS_RIGHT});
            endcase
        end
        else if (pick < 85)
        begin
            // random multi-byte character of 2, 3 or 4 bytes
            n = $urandom_range(1, 3);
            if (n == 1)
                chunk_q.push_back(8'($urandom_range(192, 223)));
            else if (n == 2)
                chunk_q.push_back(8'($urandom_range(224, 239)));
            else
                chunk_q.push_back(8'($urandom_range(240, 255)));
            for (k = 0; k < n; k++)
                chunk_q.push_back(8'($urandom_range(128, 191)));
        end
        else if (pick < 92)
            chunk_q.push_back(8'($urandom_range(128, 191)));
        else
            chunk_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_gaps_on && $urandom_range(0, 9) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        text_valid    <= 1'b1;
        text_byte     <= b;
        last_in_chunk <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_chunk();
        int i;
        int n;
        n = chunk_q.size();
        for (i = 0; i < n; i++)
            send_byte(chunk_q[i], i == n - 1);
        chunk_q.delete();
        chunks_sent++;
    endtask

    // receiver: random stall bursts, or one long hold when asked
    initial
    begin
        count_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                count_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                count_stall <= 1'b0;
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                count_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                count_stall <= 1'b0;
            end
            else
                count_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && !text_stall)
                tally.take_byte(text_byte, last_in_chunk);
            if (count_valid && !count_stall)
                tally.compare_counts(result_counts);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (text_valid && !text_stall) || (count_valid && !count_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int    rand_start;
        rst_n          = 1'b0;
        text_valid     = 1'b0;
        text_byte      = 8'h00;
        last_in_chunk  = 1'b0;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        hold_req       = 1'b0;
        bytes_sent     = 0;
        chunks_sent    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        // apostrophe before a word, accents, quote break, curly apostrophe, repeated y
        chunk_q = '{8'h27, 8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h80, 8'h9C,
                    8'hE2, 8'h80, 8'h98, 8'h79, 8'h59};
        send_chunk();
        // stray continuation, unlisted 4-byte char, nul break, partial at end
        chunk_q = '{8'h80, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00, 8'hE2};
        send_chunk();
        chunk_q = '{8'hC3, 8'h95, 8'hC2, 8'hAB, 8'h55};
        send_chunk();
        chunk_q = '{8'hFF};
        send_chunk();

        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;

        // receiver holds off while short chunks keep coming, filling the result buffer
        hold_req = 1'b1;
        repeat (12)
        begin
            add_random_char();
            send_chunk();
        end

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES || chunks_sent < MIN_CHUNKS + 16)
        begin
            if (bytes_sent - rand_start >= RAND_BYTES - 120)
            begin
                src_gaps_on    = 1'b0;
                sink_stalls_on = 1'b0;
            end
            else
            begin
                src_gaps_on    = $urandom_range(0, 3) != 0;
                sink_stalls_on = $urandom_range(0, 3) != 0;
            end
            repeat ($urandom_range(1, 16)) add_random_char();
            if ($urandom_range(0, 5) == 0)
                chunk_q.push_back(8'($urandom_range(192, 255)));
            send_chunk();
        end
        text_valid <= 1'b0;

        while (tally.expected_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d bytes in %0d chunks (directed, held receiver, random)",
                 bytes_sent, chunks_sent);
        $display("checked %0d count results, %0d mismatches", tally.results_checked,
                 tally.mismatches);
        if (tally.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
